// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, quiet while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// A stalled beat keeps the given signal unchanged in the next cycle.
`define ASSERT_STALL_HOLD(label, clk, rst, vld, rdy, sig, msg) \
   label: assert property (@(posedge clk) disable iff (rst) \
      ((vld) && !(rdy)) |=> $stable(sig)) else $error(msg);

`endif

// ----- src/i2cems_pkg.sv -----
package i2cems_pkg;

   // Sequencer steps
   typedef enum logic [3:0] {
      ST_IDLE    = 4'd0,
      ST_BEGIN   = 4'd1,
      ST_SLAW    = 4'd2,
      ST_ADDR_H  = 4'd3,
      ST_ADDR_L  = 4'd4,
      ST_REBEGIN = 4'd5,
      ST_SLAR    = 4'd6,
      ST_RX_DATA = 4'd7,
      ST_TX_DATA = 4'd8
   } step_type;

   // Bus actions
   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_START  = 3'd1;
   localparam logic [2:0] ACT_SEND   = 3'd2;
   localparam logic [2:0] ACT_RX_ACK = 3'd3;
   localparam logic [2:0] ACT_RX_NAK = 3'd4;
   localparam logic [2:0] ACT_STOP   = 3'd5;

   // Outcome codes
   localparam logic [1:0] RES_OK   = 2'd0;
   localparam logic [1:0] RES_BUSY = 2'd1;
   localparam logic [1:0] RES_FAIL = 2'd2;

   // Request kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_EVENT = 1'b1;

   // Bus controller status codes (after masking)
   localparam logic [7:0] STATUS_MASK   = 8'hF8;
   localparam logic [7:0] STATUS_FLOOR  = 8'h60;
   localparam logic [7:0] STATUS_NONE   = 8'h00;
   localparam logic [7:0] S_START       = 8'h08;
   localparam logic [7:0] S_REP_START   = 8'h10;
   localparam logic [7:0] S_MT_SLA_ACK  = 8'h18;
   localparam logic [7:0] S_MT_DATA_ACK = 8'h28;
   localparam logic [7:0] S_MR_SLA_ACK  = 8'h40;
   localparam logic [7:0] S_MR_DATA_ACK = 8'h50;
   localparam logic [7:0] S_MR_DATA_NAK = 8'h58;

   localparam logic [7:0] DEV_WRITE_MASK  = 8'hFE;
   localparam logic [7:0] RETRY_LIMIT_RST = 8'd3;

   typedef struct packed {
      logic        kind;
      logic        is_read;
      logic [7:0]  device_address;
      logic [15:0] memory_address;
      logic [15:0] transfer_length;
      logic [7:0]  bus_status;
      logic [7:0]  received_byte;
      logic [7:0]  write_byte;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [2:0]  bus_action;
      logic [7:0]  send_byte;
      logic        read_valid;
      logic [7:0]  read_byte;
      logic [15:0] byte_position;
      logic [1:0]  outcome;
   } rsp_type;

endpackage

// ----- src/i2cems_if.sv -----
// Request channel: start commands and bus status events
interface i2cems_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic        is_read;
   logic [7:0]  device_address;
   logic [15:0] memory_address;
   logic [15:0] transfer_length;
   logic [7:0]  bus_status;
   logic [7:0]  received_byte;
   logic [7:0]  write_byte;

   modport source (
      output valid, kind, is_read, device_address, memory_address, transfer_length,
             bus_status, received_byte, write_byte,
      input  ready
   );
   modport sink (
      input  valid, kind, is_read, device_address, memory_address, transfer_length,
             bus_status, received_byte, write_byte,
      output ready
   );
endinterface

// Response channel: one beat per request
interface i2cems_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [2:0]  bus_action;
   logic [7:0]  send_byte;
   logic        read_valid;
   logic [7:0]  read_byte;
   logic [15:0] byte_position;
   logic [1:0]  outcome;

   modport source (
      output valid, accepted, bus_action, send_byte, read_valid, read_byte,
             byte_position, outcome,
      input  ready
   );
   modport sink (
      input  valid, accepted, bus_action, send_byte, read_valid, read_byte,
             byte_position, outcome,
      output ready
   );
endinterface

// ----- src/i2c_eeprom_master_sequencer_unit.sv -----
// I2C master sequencer for a serial EEPROM with 16-bit byte addresses.
// Request channel (req_chan): a start beat (kind 0) opens a read or write
// transaction; a status beat (kind 1) carries the bus controller status code
// plus the byte just received and the next byte to write.
// Response channel (rsp_chan): exactly one beat per request beat, giving the
// bus action to perform, the byte to send, any delivered read byte, the buffer
// position and the transaction outcome.
// csr_we/csr_wdata write the retry limit (reset value 3).
// Output: each response is registered in the output register of the response buffer.
// Throughput: one request per cycle while req ready is high; the whole step decision is one level of
// logic between the sequencer state registers and the response register.
// Reset: the sequencer goes idle, the response channel empties and req ready
// comes up high.
// Stall: a two-entry response buffer keeps req ready high while one response
// waits; req ready drops only when two responses are held, and rises again
// once the receiver takes one.
module i2c_eeprom_master_sequencer_unit import i2cems_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   i2cems_req_if.sink    req_chan,
   i2cems_rsp_if.source  rsp_chan,
   input  logic          csr_we,
   input  logic [7:0]    csr_wdata
);

   req_type req;
   rsp_type step_rsp;
   rsp_type out_rsp;
   logic    req_fire;
   logic    push_ready;

   assign req.kind            = req_chan.kind;
   assign req.is_read         = req_chan.is_read;
   assign req.device_address  = req_chan.device_address;
   assign req.memory_address  = req_chan.memory_address;
   assign req.transfer_length = req_chan.transfer_length;
   assign req.bus_status      = req_chan.bus_status;
   assign req.received_byte   = req_chan.received_byte;
   assign req.write_byte      = req_chan.write_byte;

   assign req_chan.ready = push_ready;
   assign req_fire       = req_chan.valid && push_ready;

   i2cems_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .fire      (req_fire),
      .req       (req),
      .rsp       (step_rsp)
   );

   i2cems_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (req_fire),
      .push_data  (step_rsp),
      .push_ready (push_ready),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_data   (out_rsp)
   );

   assign rsp_chan.accepted      = out_rsp.accepted;
   assign rsp_chan.bus_action    = out_rsp.bus_action;
   assign rsp_chan.send_byte     = out_rsp.send_byte;
   assign rsp_chan.read_valid    = out_rsp.read_valid;
   assign rsp_chan.read_byte     = out_rsp.read_byte;
   assign rsp_chan.byte_position = out_rsp.byte_position;
   assign rsp_chan.outcome       = out_rsp.outcome;

endmodule

// ----- src/i2cems_core.sv -----
module i2cems_core import i2cems_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   input  logic       fire,
   input  req_type    req,
   output rsp_type    rsp
);

   step_type    step_ff, step_in;
   logic        read_mode_ff, read_mode_in;
   logic [7:0]  device_byte_ff, device_byte_in;
   logic [15:0] target_address_ff, target_address_in;
   logic [15:0] length_total_ff, length_total_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] position_ff, position_in;
   logic [7:0]  failures_ff, failures_in;
   logic [1:0]  result_code_ff, result_code_in;
   logic [7:0]  retry_limit_ff;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RETRY_LIMIT_RST;
      end else if (csr_we) begin
         retry_limit_ff <= csr_wdata;
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff           <= ST_IDLE;
         read_mode_ff      <= 1'b0;
         device_byte_ff    <= '0;
         target_address_ff <= '0;
         length_total_ff   <= '0;
         bytes_left_ff     <= '0;
         position_ff       <= '0;
         failures_ff       <= '0;
         result_code_ff    <= RES_OK;
      end else begin
         step_ff           <= step_in;
         read_mode_ff      <= read_mode_in;
         device_byte_ff    <= device_byte_in;
         target_address_ff <= target_address_in;
         length_total_ff   <= length_total_in;
         bytes_left_ff     <= bytes_left_in;
         position_ff       <= position_in;
         failures_ff       <= failures_in;
         result_code_ff    <= result_code_in;
      end
   end

   // Next state and response for one beat
   always_comb begin
      logic [7:0] st;
      logic       fail;
      logic [2:0] action;
      logic [7:0] sbyte;
      logic       rvalid;

      step_in           = step_ff;
      read_mode_in      = read_mode_ff;
      device_byte_in    = device_byte_ff;
      target_address_in = target_address_ff;
      length_total_in   = length_total_ff;
      bytes_left_in     = bytes_left_ff;
      position_in       = position_ff;
      failures_in       = failures_ff;
      result_code_in    = result_code_ff;

      st     = req.bus_status & STATUS_MASK;
      fail   = 1'b0;
      action = ACT_NONE;
      sbyte  = '0;
      rvalid = 1'b0;
      rsp    = '0;

      if (fire && req.kind == KIND_START) begin
         // Start command, taken only when idle
         if (step_ff == ST_IDLE) begin
            rsp.accepted      = 1'b1;
            read_mode_in      = req.is_read;
            device_byte_in    = req.device_address;
            target_address_in = req.memory_address;
            length_total_in   = (req.transfer_length == '0) ? 16'd1 : req.transfer_length;
            bytes_left_in     = (req.transfer_length == '0) ? 16'd1 : req.transfer_length;
            position_in       = '0;
            failures_in       = '0;
            result_code_in    = RES_BUSY;
            step_in           = ST_BEGIN;
            action            = ACT_START;
         end
      end else if (fire && step_ff != ST_IDLE && st < STATUS_FLOOR && st != STATUS_NONE) begin
         // Status event while a transaction runs
         case (step_ff)
            ST_BEGIN: begin
               if (st == S_START) begin
                  action  = ACT_SEND;
                  sbyte   = device_byte_ff & DEV_WRITE_MASK;
                  step_in = ST_SLAW;
               end else begin
                  fail = 1'b1;
               end
            end
            ST_SLAW: begin
               if (st == S_MT_SLA_ACK) begin
                  action  = ACT_SEND;
                  sbyte   = target_address_ff[15:8];
                  step_in = ST_ADDR_H;
               end else begin
                  fail = 1'b1;
               end
            end
            ST_ADDR_H: begin
               if (st == S_MT_DATA_ACK) begin
                  action  = ACT_SEND;
                  sbyte   = target_address_ff[7:0];
                  step_in = ST_ADDR_L;
               end else begin
                  fail = 1'b1;
               end
            end
            ST_ADDR_L: begin
               if (st != S_MT_DATA_ACK) begin
                  fail = 1'b1;
               end else if (read_mode_ff) begin
                  action  = ACT_START;
                  step_in = ST_REBEGIN;
               end else begin
                  action        = ACT_SEND;
                  sbyte         = req.write_byte;
                  position_in   = position_ff + 16'd1;
                  bytes_left_in = bytes_left_ff - 16'd1;
                  step_in       = ST_TX_DATA;
               end
            end
            ST_REBEGIN: begin
               if (st == S_REP_START) begin
                  action  = ACT_SEND;
                  sbyte   = (device_byte_ff & DEV_WRITE_MASK) | 8'd1;
                  step_in = ST_SLAR;
               end else begin
                  fail = 1'b1;
               end
            end
            ST_SLAR: begin
               if (st == S_MR_SLA_ACK) begin
                  action  = (bytes_left_ff > 16'd1) ? ACT_RX_ACK : ACT_RX_NAK;
                  step_in = ST_RX_DATA;
               end else begin
                  fail = 1'b1;
               end
            end
            ST_RX_DATA: begin
               if (st == S_MR_DATA_ACK && bytes_left_ff > 16'd1) begin
                  rvalid        = 1'b1;
                  position_in   = position_ff + 16'd1;
                  bytes_left_in = bytes_left_ff - 16'd1;
                  action        = (bytes_left_ff > 16'd2) ? ACT_RX_ACK : ACT_RX_NAK;
               end else if (st == S_MR_DATA_NAK && bytes_left_ff <= 16'd1) begin
                  rvalid         = 1'b1;
                  position_in    = position_ff + 16'd1;
                  bytes_left_in  = '0;
                  action         = ACT_STOP;
                  result_code_in = RES_OK;
                  step_in        = ST_IDLE;
               end else begin
                  fail = 1'b1;
               end
            end
            ST_TX_DATA: begin
               if (st != S_MT_DATA_ACK) begin
                  fail = 1'b1;
               end else if (bytes_left_ff != '0) begin
                  action        = ACT_SEND;
                  sbyte         = req.write_byte;
                  position_in   = position_ff + 16'd1;
                  bytes_left_in = bytes_left_ff - 16'd1;
               end else begin
                  action         = ACT_STOP;
                  result_code_in = RES_OK;
                  step_in        = ST_IDLE;
               end
            end
            default: begin
               fail = 1'b1;
            end
         endcase

         // Failed step: retry from the start condition or give up
         if (fail) begin
            failures_in   = failures_ff + 8'd1;
            position_in   = '0;
            bytes_left_in = length_total_ff;
            sbyte         = '0;
            rvalid        = 1'b0;
            if (failures_in < retry_limit_ff) begin
               action  = ACT_START;
               step_in = ST_BEGIN;
            end else begin
               action         = ACT_STOP;
               result_code_in = RES_FAIL;
               step_in        = ST_IDLE;
            end
         end
      end

      rsp.bus_action    = action;
      rsp.send_byte     = (action == ACT_SEND) ? sbyte : 8'd0;
      rsp.read_valid    = rvalid;
      rsp.read_byte     = rvalid ? req.received_byte : 8'd0;
      // a delivered byte reports its own index, otherwise the next one
      rsp.byte_position = rvalid ? position_ff : position_in;
      rsp.outcome       = result_code_in;
   end

endmodule

// ----- src/i2cems_skid.sv -----
module i2cems_skid import i2cems_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    push_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop        = main_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

   // Output register plus one spare slot for a beat that lands during a stall
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ----- src/i2cems_checker.sv -----
`include "assert_macros.svh"

module i2cems_checker import i2cems_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_accepted,
   input logic [2:0]  rsp_bus_action,
   input logic [7:0]  rsp_send_byte,
   input logic [1:0]  rsp_outcome
);

   // Response beat holds while stalled
   `ASSERT_CLK_RST(a_rsp_valid_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "rsp valid dropped while stalled")
   `ASSERT_STALL_HOLD(a_rsp_action_hold, clock, reset, rsp_valid, rsp_ready, rsp_bus_action, "rsp action changed while stalled")

   // Requests back up only behind a waiting response
   `ASSERT_CLK_RST(a_ready_low_needs_rsp, clock, reset, !req_ready |-> rsp_valid, "req ready low with no pending response")

   // A send byte shows only with a send action
   `ASSERT_CLK_RST(a_send_byte_clean, clock, reset, (rsp_valid && rsp_bus_action != ACT_SEND) |-> rsp_send_byte == 8'd0, "send byte without send action")

   // An accepted start always issues a start condition and reports busy
   `ASSERT_CLK_RST(a_accept_starts, clock, reset, (rsp_valid && rsp_accepted) |-> (rsp_bus_action == ACT_START && rsp_outcome == RES_BUSY), "accepted start without start action")

endmodule

bind i2c_eeprom_master_sequencer_unit i2cems_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_accepted   (rsp_chan.accepted),
   .rsp_bus_action (rsp_chan.bus_action),
   .rsp_send_byte  (rsp_chan.send_byte),
   .rsp_outcome    (rsp_chan.outcome)
);

// ----- bench/tb_i2c_eeprom_master_sequencer_unit.sv -----
module tb_i2c_eeprom_master_sequencer_unit;
   import i2cems_pkg::*;

   localparam int WD_LIMIT     = 2000;
   localparam int HOLD_CYCLES  = 200;
   localparam int PHASE_ITEMS  = 200;
   localparam int DRAIN_CYCLES = 4;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [7:0] csr_wdata;

   i2cems_req_if req_chan();
   i2cems_rsp_if rsp_chan();

   i2c_eeprom_master_sequencer_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // request beats waiting to be driven, expected response beats
   req_type req_backlog[$];
   rsp_type expected_actions[$];

   int   gen_items   = 0;
   int   req_count   = 0;
   int   rsp_seen    = 0;
   int   mismatches  = 0;
   int   idle_cycles = 0;
   int   hold_left   = 0;
   logic hold_done   = 1'b0;
   logic req_taken   = 1'b0;
   logic quiet;

   // shadow of the sequencer state
   step_type    seq_step    = ST_IDLE;
   logic        seq_read    = 1'b0;
   logic [7:0]  seq_dev     = '0;
   logic [15:0] seq_addr    = '0;
   logic [15:0] seq_len     = '0;
   logic [15:0] seq_left    = '0;
   logic [15:0] seq_pos     = '0;
   logic [7:0]  seq_fails   = '0;
   logic [1:0]  seq_outcome = RES_OK;
   logic [7:0]  limit_cfg   = RETRY_LIMIT_RST;

   // no idling on either side in this window
   assign quiet = (req_count >= 600) && (req_count < 800);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // next bus action for one request beat; updates the shadow state
   function automatic rsp_type predict_bus_action(req_type it);
      rsp_type     r;
      logic [7:0]  st;
      logic        fault;
      logic [15:0] n;
      r = '0;
      fault = 1'b0;
      r.byte_position = seq_pos;
      if (it.kind == KIND_START) begin
         if (seq_step == ST_IDLE) begin
            n = (it.transfer_length == 16'd0) ? 16'd1 : it.transfer_length;
            r.accepted  = 1'b1;
            r.bus_action = ACT_START;
            seq_read    = it.is_read;
            seq_dev     = it.device_address;
            seq_addr    = it.memory_address;
            seq_len     = n;
            seq_left    = n;
            seq_pos     = '0;
            seq_fails   = '0;
            seq_outcome = RES_BUSY;
            seq_step    = ST_BEGIN;
         end
         r.byte_position = seq_pos;
      end else begin
         st = it.bus_status & STATUS_MASK;
         if (seq_step != ST_IDLE && st < STATUS_FLOOR && st != STATUS_NONE) begin
            case (seq_step)
               ST_BEGIN: begin
                  if (st == S_START) begin
                     r.bus_action = ACT_SEND;
                     r.send_byte  = seq_dev & DEV_WRITE_MASK;
                     seq_step     = ST_SLAW;
                  end else fault = 1'b1;
               end
               ST_SLAW: begin
                  if (st == S_MT_SLA_ACK) begin
                     r.bus_action = ACT_SEND;
                     r.send_byte  = seq_addr[15:8];
                     seq_step     = ST_ADDR_H;
                  end else fault = 1'b1;
               end
               ST_ADDR_H: begin
                  if (st == S_MT_DATA_ACK) begin
                     r.bus_action = ACT_SEND;
                     r.send_byte  = seq_addr[7:0];
                     seq_step     = ST_ADDR_L;
                  end else fault = 1'b1;
               end
               ST_ADDR_L: begin
                  if (st != S_MT_DATA_ACK) begin
                     fault = 1'b1;
                  end else if (seq_read) begin
                     r.bus_action = ACT_START;
                     seq_step     = ST_REBEGIN;
                  end else begin
                     r.bus_action = ACT_SEND;
                     r.send_byte  = it.write_byte;
                     seq_pos      = seq_pos + 16'd1;
                     seq_left     = seq_left - 16'd1;
                     seq_step     = ST_TX_DATA;
                  end
               end
               ST_REBEGIN: begin
                  if (st == S_REP_START) begin
                     r.bus_action = ACT_SEND;
                     r.send_byte  = (seq_dev & DEV_WRITE_MASK) | 8'h01;
                     seq_step     = ST_SLAR;
                  end else fault = 1'b1;
               end
               ST_SLAR: begin
                  if (st == S_MR_SLA_ACK) begin
                     r.bus_action = (seq_left > 16'd1) ? ACT_RX_ACK : ACT_RX_NAK;
                     seq_step     = ST_RX_DATA;
                  end else fault = 1'b1;
               end
               ST_RX_DATA: begin
                  if (st == S_MR_DATA_ACK && seq_left > 16'd1) begin
                     r.read_valid    = 1'b1;
                     r.read_byte     = it.received_byte;
                     r.byte_position = seq_pos;
                     seq_pos         = seq_pos + 16'd1;
                     seq_left        = seq_left - 16'd1;
                     r.bus_action    = (seq_left > 16'd1) ? ACT_RX_ACK : ACT_RX_NAK;
                  end else if (st == S_MR_DATA_NAK && seq_left <= 16'd1) begin
                     r.read_valid    = 1'b1;
                     r.read_byte     = it.received_byte;
                     r.byte_position = seq_pos;
                     seq_pos         = seq_pos + 16'd1;
                     seq_left        = '0;
                     r.bus_action    = ACT_STOP;
                     seq_outcome     = RES_OK;
                     seq_step        = ST_IDLE;
                  end else fault = 1'b1;
               end
               ST_TX_DATA: begin
                  if (st != S_MT_DATA_ACK) begin
                     fault = 1'b1;
                  end else if (seq_left != 16'd0) begin
                     r.bus_action = ACT_SEND;
                     r.send_byte  = it.write_byte;
                     seq_pos      = seq_pos + 16'd1;
                     seq_left     = seq_left - 16'd1;
                  end else begin
                     r.bus_action = ACT_STOP;
                     seq_outcome  = RES_OK;
                     seq_step     = ST_IDLE;
                  end
               end
               default: fault = 1'b1;
            endcase
            // unexpected status: restart the whole transaction or give up
            if (fault) begin
               seq_fails = seq_fails + 8'd1;
               seq_pos   = '0;
               seq_left  = seq_len;
               if (seq_fails < limit_cfg) begin
                  r.bus_action = ACT_START;
                  seq_step     = ST_BEGIN;
               end else begin
                  r.bus_action = ACT_STOP;
                  seq_outcome  = RES_FAIL;
                  seq_step     = ST_IDLE;
               end
            end
            if (!r.read_valid) r.byte_position = seq_pos;
         end
      end
      if (r.bus_action != ACT_SEND) r.send_byte = '0;
      r.outcome = seq_outcome;
      return r;
   endfunction

   function automatic req_type start_beat(logic rd, logic [7:0] dev, logic [15:0] addr,
                                          logic [15:0] len);
      req_type it;
      it.kind            = KIND_START;
      it.is_read         = rd;
      it.device_address  = dev;
      it.memory_address  = addr;
      it.transfer_length = len;
      it.bus_status      = 8'($urandom);
      it.received_byte   = 8'($urandom);
      it.write_byte      = 8'($urandom);
      return it;
   endfunction

   // status beat; the masked low bits get random values
   function automatic req_type status_beat(logic [7:0] code);
      req_type it;
      it.kind            = KIND_EVENT;
      it.is_read         = 1'($urandom);
      it.device_address  = 8'($urandom);
      it.memory_address  = 16'($urandom);
      it.transfer_length = 16'($urandom);
      it.bus_status      = code | {5'b0, 3'($urandom)};
      it.received_byte   = 8'($urandom);
      it.write_byte      = 8'($urandom);
      return it;
   endfunction

   // status the bus controller reports at position i of a clean attempt
   function automatic logic [7:0] expected_status(logic rd, int i, int total);
      if (i == 0) return S_START;
      if (i == 1) return S_MT_SLA_ACK;
      if (!rd || i < 4) return S_MT_DATA_ACK;
      if (i == 4) return S_REP_START;
      if (i == 5) return S_MR_SLA_ACK;
      return (i == total - 1) ? S_MR_DATA_NAK : S_MR_DATA_ACK;
   endfunction

   // a live status code other than the one the sequencer waits for
   function automatic logic [7:0] wrong_status(logic [7:0] want);
      logic [7:0] bad;
      if (want == S_MR_DATA_ACK && $urandom_range(0, 1) == 1) return S_MR_DATA_NAK;
      if (want == S_MR_DATA_NAK && $urandom_range(0, 1) == 1) return S_MR_DATA_ACK;
      bad = {5'($urandom_range(1, 11)), 3'b000};
      if (bad == want) bad = (bad == S_MR_DATA_NAK) ? S_START : bad + 8'h08;
      return bad;
   endfunction

   // beats the sequencer must ignore or refuse
   task automatic queue_noise(logic busy);
      case ($urandom_range(0, 2))
         0: begin
            if (busy) begin
               req_backlog.push_back(start_beat(1'($urandom), 8'($urandom),
                                                16'($urandom), 16'($urandom)));
            end else begin
               req_backlog.push_back(status_beat({5'($urandom_range(1, 11)), 3'b000}));
            end
         end
         1: req_backlog.push_back(status_beat(STATUS_NONE));
         default: req_backlog.push_back(status_beat({5'($urandom_range(12, 31)), 3'b000}));
      endcase
   endtask

   // one full transaction with random content, broken attempts and retries
   task automatic queue_transaction();
      logic        rd;
      logic [15:0] len;
      logic [7:0]  want;
      logic        broke;
      logic        done;
      int          n, total, i, fails, err_pct, pick;
      rd = 1'($urandom);
      pick = $urandom_range(0, 99);
      err_pct = 4;
      if (pick < 3) begin
         len = '0;
      end else if (pick < 85) begin
         len = 16'($urandom_range(1, 6));
      end else if (pick < 97 || limit_cfg > 8'd4) begin
         len = 16'($urandom_range(7, 40));
      end else begin
         // random full-width length with a high error rate, mostly aborted through the retry limit
         len = 16'($urandom);
         err_pct = 30;
      end
      n = (len == 16'd0) ? 1 : int'(len);
      req_backlog.push_back(start_beat(rd, 8'($urandom), 16'($urandom), len));
      gen_items++;
      fails = 0;
      done = 1'b0;
      while (!done) begin
         total = rd ? n + 6 : n + 4;
         broke = 1'b0;
         for (i = 0; i < total && !broke; i++) begin
            if ($urandom_range(0, 99) < 4) queue_noise(1'b1);
            want = expected_status(rd, i, total);
            if ($urandom_range(0, 99) < err_pct) begin
               req_backlog.push_back(status_beat(wrong_status(want)));
               broke = 1'b1;
               fails++;
            end else begin
               req_backlog.push_back(status_beat(want));
            end
            gen_items++;
         end
         done = !broke || (fails >= limit_cfg);
      end
   endtask

   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_chan.valid || expected_actions.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_retry_limit(logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      limit_cfg = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // request driver: presents one beat at a time from the backlog
   always @(negedge clock) begin
      req_type it;
      if (!reset && (!req_chan.valid || req_taken)) begin
         if (req_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= 9)) begin
            it = req_backlog.pop_front();
            req_chan.valid           <= 1'b1;
            req_chan.kind            <= it.kind;
            req_chan.is_read         <= it.is_read;
            req_chan.device_address  <= it.device_address;
            req_chan.memory_address  <= it.memory_address;
            req_chan.transfer_length <= it.transfer_length;
            req_chan.bus_status      <= it.bus_status;
            req_chan.received_byte   <= it.received_byte;
            req_chan.write_byte      <= it.write_byte;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response ready: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!hold_done && rsp_seen >= 300 && req_backlog.size() > 50) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= quiet || ($urandom_range(0, 99) >= 9);
      end
   end

   // monitor: check response beats, predict accepted request beats
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      req_type seen;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{accepted: rsp_chan.accepted, bus_action: rsp_chan.bus_action,
                    send_byte: rsp_chan.send_byte, read_valid: rsp_chan.read_valid,
                    read_byte: rsp_chan.read_byte, byte_position: rsp_chan.byte_position,
                    outcome: rsp_chan.outcome};
            rsp_seen++;
            if (expected_actions.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("response beat %0d not expected: %p", rsp_seen, got);
            end else begin
               want = expected_actions.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display({"beat %0d (exp/got): accepted %0b/%0b action %0d/%0d ",
                               "send %02h/%02h rvalid %0b/%0b rbyte %02h/%02h ",
                               "pos %0d/%0d outcome %0d/%0d"},
                              rsp_seen, want.accepted, got.accepted,
                              want.bus_action, got.bus_action, want.send_byte, got.send_byte,
                              want.read_valid, got.read_valid, want.read_byte, got.read_byte,
                              want.byte_position, got.byte_position,
                              want.outcome, got.outcome);
                  end
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            seen = '{kind: req_chan.kind, is_read: req_chan.is_read,
                     device_address: req_chan.device_address,
                     memory_address: req_chan.memory_address,
                     transfer_length: req_chan.transfer_length,
                     bus_status: req_chan.bus_status,
                     received_byte: req_chan.received_byte,
                     write_byte: req_chan.write_byte};
            expected_actions.push_back(predict_bus_action(seen));
            req_count++;
         end
      end
   end

   // watchdog on cycles without any beat or register write
   always @(posedge clock) begin
      if (reset || csr_we || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WD_LIMIT) begin
         $display("tb_i2c_eeprom_master_sequencer_unit failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [7:0] limit_plan [5];
      int         p;
      reset                    = 1'b1;
      csr_we                   = 1'b0;
      csr_wdata                = '0;
      req_chan.valid           = 1'b0;
      req_chan.kind            = KIND_START;
      req_chan.is_read         = 1'b0;
      req_chan.device_address  = '0;
      req_chan.memory_address  = '0;
      req_chan.transfer_length = '0;
      req_chan.bus_status      = '0;
      req_chan.received_byte   = '0;
      req_chan.write_byte      = '0;
      rsp_chan.ready           = 1'b0;
      limit_plan[0] = 8'd1;
      limit_plan[1] = 8'd255;
      limit_plan[2] = 8'd0;
      limit_plan[3] = 8'($urandom_range(2, 8));
      limit_plan[4] = 8'($urandom_range(1, 255));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: status while idle is ignored
      req_backlog.push_back(status_beat(S_START));
      // write, zero length taken as one, all-ones address and device
      req_backlog.push_back(start_beat(1'b0, 8'hFF, 16'hFFFF, 16'h0000));
      req_backlog.push_back(status_beat(S_START));
      req_backlog.push_back(status_beat(S_MT_SLA_ACK));
      req_backlog.push_back(status_beat(STATUS_FLOOR));
      req_backlog.push_back(status_beat(S_MT_DATA_ACK));
      req_backlog.push_back(start_beat(1'b1, 8'h00, 16'h0000, 16'hFFFF));
      req_backlog.push_back(status_beat(S_MT_DATA_ACK));
      req_backlog.push_back(status_beat(STATUS_NONE));
      req_backlog.push_back(status_beat(S_MT_DATA_ACK));
      // read of one byte, data acked where a nak was due, then out of retries
      req_backlog.push_back(start_beat(1'b1, 8'h00, 16'h0000, 16'd1));
      req_backlog.push_back(status_beat(S_START));
      req_backlog.push_back(status_beat(S_MT_SLA_ACK));
      req_backlog.push_back(status_beat(S_MT_DATA_ACK));
      req_backlog.push_back(status_beat(S_MT_DATA_ACK));
      req_backlog.push_back(status_beat(S_REP_START));
      req_backlog.push_back(status_beat(S_MR_SLA_ACK));
      req_backlog.push_back(status_beat(S_MR_DATA_ACK));
      req_backlog.push_back(status_beat(S_MR_DATA_NAK));
      req_backlog.push_back(status_beat(S_MT_SLA_ACK));
      // full-length write broken after the device address byte
      req_backlog.push_back(start_beat(1'b0, 8'hA5, 16'h8001, 16'hFFFF));
      req_backlog.push_back(status_beat(S_START));
      req_backlog.push_back(status_beat(S_MT_SLA_ACK));
      req_backlog.push_back(status_beat(S_MR_SLA_ACK));
      req_backlog.push_back(status_beat(S_REP_START));
      req_backlog.push_back(status_beat(S_MT_DATA_ACK));
      wait_drained();

      // random phases, one retry limit each
      for (p = 0; p < 5; p++) begin
         write_retry_limit(limit_plan[p]);
         gen_items = 0;
         while (gen_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 5) queue_noise(1'b0);
            queue_transaction();
         end
         wait_drained();
      end

      if (mismatches == 0 && expected_actions.size() == 0) begin
         $display("tb_i2c_eeprom_master_sequencer_unit passed");
      end else begin
         $display("tb_i2c_eeprom_master_sequencer_unit failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/i2cems_pkg.sv
src/i2cems_if.sv
src/i2cems_core.sv
src/i2cems_skid.sv
src/i2c_eeprom_master_sequencer_unit.sv
src/i2cems_checker.sv
bench/tb_i2c_eeprom_master_sequencer_unit.sv
